[rtl/core/sm4_block_encrypt_core_defines.svh]
// Assertion macros shared by the SM4 encrypt core RTL
`ifndef SM4_BLOCK_ENCRYPT_CORE_DEFINES_SVH
`define SM4_BLOCK_ENCRYPT_CORE_DEFINES_SVH

// same-cycle implication
`define SM4_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sm4 assertion failed");

// next-cycle implication
`define SM4_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sm4 assertion failed");

`endif

[rtl/core/sm4_pkg.sv]
// SM4 package: types, S-box, FK/CK constants and round functions
`timescale 1ns / 1ps

package sm4_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [3:0] quad_t;

	// word 0 is the oldest word of each shift register
	typedef struct packed {
		quad_t x;
		quad_t k;
	} stage_t;

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_idx_t;

	localparam int NUM_ROUNDS = 32;

	localparam word_t FK0 = 32'ha3b1bac6;
	localparam word_t FK1 = 32'h56aa3350;
	localparam word_t FK2 = 32'h677d9197;
	localparam word_t FK3 = 32'hb27022dc;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic word_t sub_word(word_t w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// CK byte j of word i is (4i+j)*7 mod 256
	function automatic word_t ck_word(logic [5:0] i);
		word_t w;
		w = '0;
		for (int j = 0; j < 4; j++) begin
			w = {w[23:0], 8'(({2'b00, i} << 2) + 8'(j)) * 8'd7};
		end
		return w;
	endfunction

	// L for cipher rounds: rotations 2, 10, 18, 24
	function automatic word_t l_data(word_t t);
		return t ^ {t[29:0], t[31:30]} ^ {t[21:0], t[31:22]}
			^ {t[13:0], t[31:14]} ^ {t[7:0], t[31:8]};
	endfunction

	// L' for key rounds: rotations 13, 23
	function automatic word_t l_key(word_t t);
		return t ^ {t[18:0], t[31:19]} ^ {t[8:0], t[31:9]};
	endfunction

	function automatic word_t key_round(quad_t k, logic [5:0] i);
		return k[0] ^ l_key(sub_word(k[1] ^ k[2] ^ k[3] ^ ck_word(i)));
	endfunction

endpackage

[rtl/core/sm4_cell.sv]
// SM4 round cell: one cipher round plus the next key round, registered
`timescale 1ns / 1ps
`include "sm4_block_encrypt_core_defines.svh"

module sm4_cell #(
	parameter int ROUND = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  sm4_pkg::stage_t in_stage,
	output logic            out_valid,
	output sm4_pkg::stage_t out_stage
);

	// in_stage.k[3] is the round key for this round
	sm4_pkg::word_t  x_new;
	sm4_pkg::word_t  rk_next;
	sm4_pkg::stage_t stage_s1;
	logic            valid_s1;

	assign x_new = in_stage.x[0] ^ sm4_pkg::l_data(sm4_pkg::sub_word(
		in_stage.x[1] ^ in_stage.x[2] ^ in_stage.x[3] ^ in_stage.k[3]));
	assign rk_next = sm4_pkg::key_round(in_stage.k, 6'(ROUND + 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		stage_s1.x <= {x_new, in_stage.x[3], in_stage.x[2], in_stage.x[1]};
		stage_s1.k <= {rk_next, in_stage.k[3], in_stage.k[2], in_stage.k[1]};
	end

	assign out_valid = valid_s1;
	assign out_stage = stage_s1;

	`SM4_ASSERT_NEXT(a_valid_moves, clk, arst_n, in_valid, valid_s1)
	`SM4_ASSERT_NEXT(a_bubble_moves, clk, arst_n, !in_valid, !valid_s1)
	`SM4_ASSERT_NEXT(a_words_shift, clk, arst_n, in_valid,
		stage_s1.x[0] == $past(in_stage.x[1]) && stage_s1.k[2] == $past(in_stage.k[3]))

endmodule

[rtl/core/sm4_block_encrypt_core.sv]
// SM4 encrypt core: key registers, key whitening stage and a chain of 32 round cells
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------------------------
//  input    | start, busy       | plain_high, plain_low
//  result   | done (strobe)     | cipher_high, cipher_low
//  config   | cfg_we            | cfg_index, cfg_wdata
//
// One block accepted per cycle; busy is never raised.
// Each block passes through one key whitening stage plus one cell per round.
// The entry stage and the 32 cells hold up to 33 beats; the first round key is made at entry.
// Reset clears valid flags and the key registers (key all zeros).
// The result strobe cannot be stalled; each done lasts one cycle.
`timescale 1ns / 1ps
`include "sm4_block_encrypt_core_defines.svh"

module sm4_block_encrypt_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] plain_high,
	input  logic [63:0] plain_low,
	output logic        done,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	logic [63:0]     key_high_q;
	logic [63:0]     key_low_q;
	sm4_pkg::quad_t  k_init;
	sm4_pkg::word_t  rk_first;
	logic            accept;
	logic            valid_s0;
	sm4_pkg::stage_t stage_s0;

	logic            chain_valid [sm4_pkg::NUM_ROUNDS+1];
	sm4_pkg::stage_t chain_stage [sm4_pkg::NUM_ROUNDS+1];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sm4_pkg::REG_KEY_HIGH: key_high_q <= cfg_wdata;
				sm4_pkg::REG_KEY_LOW:  key_low_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign k_init[0] = key_high_q[63:32] ^ sm4_pkg::FK0;
	assign k_init[1] = key_high_q[31:0]  ^ sm4_pkg::FK1;
	assign k_init[2] = key_low_q[63:32]  ^ sm4_pkg::FK2;
	assign k_init[3] = key_low_q[31:0]   ^ sm4_pkg::FK3;
	assign rk_first  = sm4_pkg::key_round(k_init, 6'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		stage_s0.x <= {plain_low[31:0], plain_low[63:32], plain_high[31:0], plain_high[63:32]};
		stage_s0.k <= {rk_first, k_init[3], k_init[2], k_init[1]};
	end

	assign chain_valid[0] = valid_s0;
	assign chain_stage[0] = stage_s0;

	for (genvar r = 0; r < sm4_pkg::NUM_ROUNDS; r++) begin : g_round
		sm4_cell #(
			.ROUND(r)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[r]),
			.in_stage  (chain_stage[r]),
			.out_valid (chain_valid[r+1]),
			.out_stage (chain_stage[r+1])
		);
	end

	// output is the last four words in reverse order
	assign done        = chain_valid[sm4_pkg::NUM_ROUNDS];
	assign cipher_high = {chain_stage[sm4_pkg::NUM_ROUNDS].x[3],
		chain_stage[sm4_pkg::NUM_ROUNDS].x[2]};
	assign cipher_low  = {chain_stage[sm4_pkg::NUM_ROUNDS].x[1],
		chain_stage[sm4_pkg::NUM_ROUNDS].x[0]};

	`SM4_ASSERT_NEXT(a_accept_enters, clk, arst_n, accept, valid_s0)
	`SM4_ASSERT_IMPL(a_done_latency, clk, arst_n, done, $past(valid_s0, 32))
	`SM4_ASSERT_NEXT(a_key_low_write, clk, arst_n,
		cfg_we && cfg_index == sm4_pkg::REG_KEY_LOW, key_low_q == $past(cfg_wdata))

endmodule

[bench/sm4_block_encrypt_core_tb.sv]
// Self-checking testbench for the SM4 block encrypt core: directed vectors, random blocks, rekeying
`timescale 1ns / 1ps

module sm4_block_encrypt_core_tb;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} cipher_t;

	localparam logic [7:0] SBOX_TBL [256] = '{
		'hd6,'h90,'he9,'hfe,'hcc,'he1,'h3d,'hb7,'h16,'hb6,'h14,'hc2,'h28,'hfb,'h2c,'h05,
		'h2b,'h67,'h9a,'h76,'h2a,'hbe,'h04,'hc3,'haa,'h44,'h13,'h26,'h49,'h86,'h06,'h99,
		'h9c,'h42,'h50,'hf4,'h91,'hef,'h98,'h7a,'h33,'h54,'h0b,'h43,'hed,'hcf,'hac,'h62,
		'he4,'hb3,'h1c,'ha9,'hc9,'h08,'he8,'h95,'h80,'hdf,'h94,'hfa,'h75,'h8f,'h3f,'ha6,
		'h47,'h07,'ha7,'hfc,'hf3,'h73,'h17,'hba,'h83,'h59,'h3c,'h19,'he6,'h85,'h4f,'ha8,
		'h68,'h6b,'h81,'hb2,'h71,'h64,'hda,'h8b,'hf8,'heb,'h0f,'h4b,'h70,'h56,'h9d,'h35,
		'h1e,'h24,'h0e,'h5e,'h63,'h58,'hd1,'ha2,'h25,'h22,'h7c,'h3b,'h01,'h21,'h78,'h87,
		'hd4,'h00,'h46,'h57,'h9f,'hd3,'h27,'h52,'h4c,'h36,'h02,'he7,'ha0,'hc4,'hc8,'h9e,
		'hea,'hbf,'h8a,'hd2,'h40,'hc7,'h38,'hb5,'ha3,'hf7,'hf2,'hce,'hf9,'h61,'h15,'ha1,
		'he0,'hae,'h5d,'ha4,'h9b,'h34,'h1a,'h55,'had,'h93,'h32,'h30,'hf5,'h8c,'hb1,'he3,
		'h1d,'hf6,'he2,'h2e,'h82,'h66,'hca,'h60,'hc0,'h29,'h23,'hab,'h0d,'h53,'h4e,'h6f,
		'hd5,'hdb,'h37,'h45,'hde,'hfd,'h8e,'h2f,'h03,'hff,'h6a,'h72,'h6d,'h6c,'h5b,'h51,
		'h8d,'h1b,'haf,'h92,'hbb,'hdd,'hbc,'h7f,'h11,'hd9,'h5c,'h41,'h1f,'h10,'h5a,'hd8,
		'h0a,'hc1,'h31,'h88,'ha5,'hcd,'h7b,'hbd,'h2d,'h74,'hd0,'h12,'hb8,'he5,'hb4,'hb0,
		'h89,'h69,'h97,'h4a,'h0c,'h96,'h77,'h7e,'h65,'hb9,'hf1,'h09,'hc5,'h6e,'hc6,'h84,
		'h18,'hf0,'h7d,'hec,'h3a,'hdc,'h4d,'h20,'h79,'hee,'h5f,'h3e,'hd7,'hcb,'h39,'h48
	};

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [63:0] plain_high;
	logic [63:0] plain_low;
	logic done;
	logic [63:0] cipher_high;
	logic [63:0] cipher_low;
	logic cfg_we;
	sm4_pkg::reg_idx_t cfg_index;
	logic [63:0] cfg_wdata;

	logic [63:0] key_hi;
	logic [63:0] key_lo;
	cipher_t pending_cipher [$];
	cipher_t head_cipher;
	int send_idle_pct;
	int mismatch_cnt = 0;

	sm4_block_encrypt_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.plain_high(plain_high),
		.plain_low(plain_low),
		.done(done),
		.cipher_high(cipher_high),
		.cipher_low(cipher_low),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(2_000_000);
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		return {SBOX_TBL[w[31:24]], SBOX_TBL[w[23:16]], SBOX_TBL[w[15:8]], SBOX_TBL[w[7:0]]};
	endfunction

	function automatic logic [127:0] sm4_encrypt(input logic [127:0] key, input logic [127:0] blk);
		logic [31:0] rk [4];
		logic [31:0] x [4];
		logic [31:0] ck, t, nk, nx;
		logic [7:0] b;
		int i, j;
		rk[0] = key[127:96] ^ 32'ha3b1bac6;
		rk[1] = key[95:64] ^ 32'h56aa3350;
		rk[2] = key[63:32] ^ 32'h677d9197;
		rk[3] = key[31:0] ^ 32'hb27022dc;
		x[0] = blk[127:96];
		x[1] = blk[95:64];
		x[2] = blk[63:32];
		x[3] = blk[31:0];
		for (i = 0; i < 32; i++) begin
			ck = '0;
			for (j = 0; j < 4; j++) begin
				b = 8'((4 * i + j) * 7);
				ck = {ck[23:0], b};
			end
			t = sbox_word(rk[1] ^ rk[2] ^ rk[3] ^ ck);
			nk = rk[0] ^ t ^ rotl32(t, 13) ^ rotl32(t, 23);
			rk[0] = rk[1]; rk[1] = rk[2]; rk[2] = rk[3]; rk[3] = nk;
			t = sbox_word(x[1] ^ x[2] ^ x[3] ^ nk);
			nx = x[0] ^ t ^ rotl32(t, 2) ^ rotl32(t, 10) ^ rotl32(t, 18) ^ rotl32(t, 24);
			x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
		end
		return {x[3], x[2], x[1], x[0]};
	endfunction

	function automatic logic [63:0] rand64();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatch_cnt < 20)
			$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_block(input logic [63:0] ph, input logic [63:0] pl);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			plain_high <= {$urandom, $urandom};
			plain_low <= {$urandom, $urandom};
			@(negedge clk);
		end
		start <= 1'b1;
		plain_high <= ph;
		plain_low <= pl;
		do begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end while (!taken);
		pending_cipher.push_back(sm4_encrypt({key_hi, key_lo}, {ph, pl}));
	endtask

	task automatic drain_blocks();
		start <= 1'b0;
		while (pending_cipher.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_key(input sm4_pkg::reg_idx_t idx, input logic [63:0] val);
		drain_blocks();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == sm4_pkg::REG_KEY_HIGH)
			key_hi = val;
		else
			key_lo = val;
		@(negedge clk);
	endtask

	// one beat per strobe, checked against the oldest pending block
	always @(posedge clk) begin
		if (arst_n) begin
			if ($isunknown(done)) begin
				report_mismatch("done unknown", {63'd0, done}, 64'd0);
			end else if (done) begin
				if (pending_cipher.size() == 0) begin
					report_mismatch("unexpected result", cipher_high, 64'd0);
				end else begin
					head_cipher = pending_cipher.pop_front();
					if (cipher_high !== head_cipher.hi)
						report_mismatch("cipher_high", cipher_high, head_cipher.hi);
					if (cipher_low !== head_cipher.lo)
						report_mismatch("cipher_low", cipher_low, head_cipher.lo);
				end
			end
		end
	end

	// key never written: all-zero key
	task automatic test_zero_key();
		send_block(64'h0, 64'h0);
		send_block('1, '1);
		send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
	endtask

	task automatic test_known_answer();
		logic [127:0] kat;
		kat = sm4_encrypt(128'h0123456789abcdeffedcba9876543210,
			128'h0123456789abcdeffedcba9876543210);
		if (kat !== 128'h681edf34d206965e86b3e94f536e4246)
			report_mismatch("known-answer prediction", kat[127:64], 64'h681edf34d206965e);
		write_key(sm4_pkg::REG_KEY_HIGH, 64'h0123456789abcdef);
		write_key(sm4_pkg::REG_KEY_LOW, 64'hfedcba9876543210);
		send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
	endtask

	task automatic test_key_extremes();
		write_key(sm4_pkg::REG_KEY_HIGH, '1);
		write_key(sm4_pkg::REG_KEY_LOW, '1);
		send_block(64'h0, 64'h0);
		send_block('1, '1);
		send_block(64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a);
		write_key(sm4_pkg::REG_KEY_HIGH, 64'h0);
		send_block(64'h8000000000000000, 64'h1);
		write_key(sm4_pkg::REG_KEY_LOW, 64'h0);
		write_key(sm4_pkg::REG_KEY_HIGH, 64'h8000000000000000);
		send_block('1, 64'h0);
		write_key(sm4_pkg::REG_KEY_HIGH, 64'h0);
		send_block(64'h0, '1);
	endtask

	task automatic test_random(input int idle_pct, input int n_blocks);
		int left, chunk, i;
		logic [127:0] blk;
		send_idle_pct = idle_pct;
		left = n_blocks;
		blk = '0;
		while (left > 0) begin
			case ($urandom_range(3))
				0: write_key(sm4_pkg::REG_KEY_HIGH, rand64());
				1: write_key(sm4_pkg::REG_KEY_LOW, rand64());
				default: begin
					write_key(sm4_pkg::REG_KEY_HIGH, rand64());
					write_key(sm4_pkg::REG_KEY_LOW, rand64());
				end
			endcase
			chunk = $urandom_range(30, 110);
			if (chunk > left)
				chunk = left;
			for (i = 0; i < chunk; i++) begin
				// single-bit flips of the previous block exercise diffusion
				if (i > 0 && $urandom_range(4) == 0)
					blk = blk ^ (128'd1 << $urandom_range(127));
				else
					blk = {rand64(), rand64()};
				send_block(blk[127:64], blk[63:0]);
			end
			left -= chunk;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		plain_high = '0;
		plain_low = '0;
		cfg_we = 1'b0;
		cfg_index = sm4_pkg::REG_KEY_HIGH;
		cfg_wdata = '0;
		key_hi = '0;
		key_lo = '0;
		send_idle_pct = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_zero_key();
		test_known_answer();
		test_key_extremes();
		test_random(36, 450);
		test_random(79, 450);
		test_random(0, 450);
		drain_blocks();
		repeat (40) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/sm4_pkg.sv
rtl/core/sm4_cell.sv
rtl/core/sm4_block_encrypt_core.sv
bench/sm4_block_encrypt_core_tb.sv
